// ===== hdl/psx_pkg.sv =====
// Shared types and codes for the PDU signal extractor.
package psx_pkg;

  // Input kind codes
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  // Byte order codes
  localparam logic [1:0] END_BIG    = 2'd0;
  localparam logic [1:0] END_LITTLE = 2'd1;
  localparam logic [1:0] END_OPAQUE = 2'd2;
  localparam logic [1:0] END_RSVD   = 2'd3;

  // Signal type codes
  localparam logic [3:0] TY_BOOL     = 4'd0;
  localparam logic [3:0] TY_U8       = 4'd1;
  localparam logic [3:0] TY_U16      = 4'd2;
  localparam logic [3:0] TY_U32      = 4'd3;
  localparam logic [3:0] TY_U64      = 4'd4;
  localparam logic [3:0] TY_U8_ARRAY = 4'd5;
  localparam logic [3:0] TY_DYN      = 4'd6;
  localparam logic [3:0] TY_S8       = 4'd7;
  localparam logic [3:0] TY_S16      = 4'd8;
  localparam logic [3:0] TY_S32      = 4'd9;
  localparam logic [3:0] TY_S64      = 4'd10;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Command opcodes between front and back
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_COPY  = 3'd1;
  localparam logic [2:0] OP_EMPTY = 3'd2;
  localparam logic [2:0] OP_UNSUP = 3'd3;
  localparam logic [2:0] OP_NUM   = 3'd4;

  // Result width classes
  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;
  localparam logic [1:0] WC_32 = 2'd2;

  // Sizes
  localparam logic [6:0] MAX_COPY  = 7'd64;
  localparam int         NUM_BYTES = 5;
  localparam int         CQ_DEPTH  = 2;
  localparam int         CQ_AW     = 1;
  localparam int         RQ_DEPTH  = 4;
  localparam int         RQ_AW     = 2;

  // Classified command
  typedef struct packed {
    logic [2:0] op;
    logic [8:0] addr;     // write index, copy start byte or numeric anchor byte
    logic [7:0] data;     // write data
    logic [6:0] count;    // copy length in bytes
    logic [5:0] size;     // numeric bit size, 1..32
    logic [2:0] shift;    // bit offset inside the anchor byte
    logic       big_end;  // numeric bytes go downward from the anchor
    logic [1:0] wclass;
    logic       sgn;
  } cmd_t;

  // One result
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic        last;
  } res_t;

endpackage

// ===== hdl/psx_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
module psx_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [5:0]        byte_index,
  input  logic [7:0]        byte_value,
  input  logic [8:0]        bit_position,
  input  logic [9:0]        bit_size,
  input  logic [1:0]        endianness,
  input  logic [3:0]        signal_type,
  output logic              cmd_valid,
  output psx_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);

  psx_pkg::cmd_t              cls;
  logic [6:0]                 nbytes;
  psx_pkg::cmd_t              q [psx_pkg::CQ_DEPTH];
  logic [psx_pkg::CQ_AW-1:0]  wp;
  logic [psx_pkg::CQ_AW-1:0]  rp;
  logic [psx_pkg::CQ_AW:0]    cnt;
  logic                       push;

  // Classify the incoming transaction
  always_comb begin
    cls    = '0;
    nbytes = bit_size[9:3];
    if (kind == psx_pkg::KIND_WRITE) begin
      cls.op   = psx_pkg::OP_WRITE;
      cls.addr = 9'(byte_index);
      cls.data = byte_value;
    end else if (endianness == psx_pkg::END_OPAQUE || signal_type == psx_pkg::TY_U8_ARRAY) begin
      cls.addr  = 9'(bit_position[8:3]);
      cls.count = (nbytes > psx_pkg::MAX_COPY) ? psx_pkg::MAX_COPY : nbytes;
      cls.op    = (nbytes == 7'd0) ? psx_pkg::OP_EMPTY : psx_pkg::OP_COPY;
    end else if (endianness == psx_pkg::END_RSVD || signal_type == psx_pkg::TY_U64 ||
                 signal_type == psx_pkg::TY_DYN || signal_type >= psx_pkg::TY_S64) begin
      cls.op = psx_pkg::OP_UNSUP;
    end else begin
      cls.op      = psx_pkg::OP_NUM;
      cls.addr    = 9'(bit_position[8:3]);
      cls.shift   = bit_position[2:0];
      cls.big_end = (endianness == psx_pkg::END_BIG);
      if (bit_size == 10'd0) begin
        cls.size = 6'd1;
      end else if (bit_size > 10'd32) begin
        cls.size = 6'd32;
      end else begin
        cls.size = bit_size[5:0];
      end
      cls.sgn = (signal_type == psx_pkg::TY_S8 || signal_type == psx_pkg::TY_S16 ||
                 signal_type == psx_pkg::TY_S32);
      if (signal_type == psx_pkg::TY_BOOL || signal_type == psx_pkg::TY_U8 ||
          signal_type == psx_pkg::TY_S8) begin
        cls.wclass = psx_pkg::WC_8;
      end else if (signal_type == psx_pkg::TY_U16 || signal_type == psx_pkg::TY_S16) begin
        cls.wclass = psx_pkg::WC_16;
      end else begin
        cls.wclass = psx_pkg::WC_32;
      end
    end
  end

  // Command queue
  assign in_stall  = (cnt == (psx_pkg::CQ_AW+1)'(psx_pkg::CQ_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt != '0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (cmd_pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (psx_pkg::CQ_AW+1)'(push) - (psx_pkg::CQ_AW+1)'(cmd_pop);
    end
  end

endmodule

// ===== hdl/psx_back.sv =====
// Back end: PDU buffer, byte gathering, numeric extraction and result queue.
module psx_back #(
  parameter int PDU_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  psx_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       value,
  output logic [1:0]        status,
  output logic              last
);

  localparam int         AW     = (PDU_BYTES > 1) ? $clog2(PDU_BYTES) : 1;
  localparam logic [8:0] DEPTH9 = 9'(PDU_BYTES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_NUM  = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;

  logic [7:0]                mem [PDU_BYTES];
  logic [PDU_BYTES-1:0]      written;

  logic [1:0]                state;
  psx_pkg::cmd_t             cur;
  logic [6:0]                k;
  logic                      rd_pend;
  logic                      rd_num;
  logic                      rd_last;
  logic                      rd_hit;
  logic [7:0]                mem_q;
  logic [31:0]               acc;

  psx_pkg::res_t             rq [psx_pkg::RQ_DEPTH];
  logic [psx_pkg::RQ_AW-1:0] rq_wp;
  logic [psx_pkg::RQ_AW-1:0] rq_rp;
  logic [psx_pkg::RQ_AW:0]   rq_cnt;
  logic                      rq_room;
  logic                      rq_room_pend;
  logic                      rq_pop;

  logic [8:0]                idx9;
  logic                      idx_ok;
  logic                      issue;
  logic                      last_issue;
  logic                      wr_en;
  logic                      idle_push;
  logic [1:0]                idle_status;
  logic [7:0]                rd_byte;
  logic [39:0]               word;
  logic [31:0]               shifted;
  logic [31:0]               mask;
  logic [31:0]               signmask;
  logic [31:0]               ext;
  logic                      res_push;
  psx_pkg::res_t             res_in;

  // Queue space checks
  assign rq_room      = (rq_cnt < (psx_pkg::RQ_AW+1)'(psx_pkg::RQ_DEPTH));
  assign rq_room_pend = ((rq_cnt + (psx_pkg::RQ_AW+1)'(rd_pend)) <
                         (psx_pkg::RQ_AW+1)'(psx_pkg::RQ_DEPTH));

  // Command dispatch while idle
  always_comb begin
    cmd_pop     = 1'b0;
    idle_push   = 1'b0;
    idle_status = psx_pkg::ST_OK;
    if (state == ST_IDLE && !rd_pend && cmd_valid) begin
      unique case (cmd.op)
        psx_pkg::OP_WRITE, psx_pkg::OP_COPY: begin
          cmd_pop = 1'b1;
        end
        psx_pkg::OP_NUM: begin
          cmd_pop = rq_room;
        end
        psx_pkg::OP_UNSUP: begin
          cmd_pop     = rq_room;
          idle_push   = rq_room;
          idle_status = psx_pkg::ST_UNSUP;
        end
        psx_pkg::OP_EMPTY: begin
          cmd_pop     = rq_room;
          idle_push   = rq_room;
          idle_status = psx_pkg::ST_EMPTY;
        end
        default: begin
          cmd_pop = 1'b1;
        end
      endcase
    end
  end

  assign wr_en = cmd_pop && (cmd.op == psx_pkg::OP_WRITE) && (cmd.addr < DEPTH9);

  // Read address sequencing
  assign idx9   = cur.big_end ? (cur.addr - 9'(k)) : (cur.addr + 9'(k));
  assign idx_ok = !idx9[8] && (idx9 < DEPTH9);

  always_comb begin
    issue      = 1'b0;
    last_issue = 1'b0;
    unique case (state)
      ST_NUM: begin
        issue      = 1'b1;
        last_issue = (k == 7'(psx_pkg::NUM_BYTES - 1));
      end
      ST_COPY: begin
        issue      = rq_room_pend;
        last_issue = (k == cur.count - 7'd1);
      end
      default: begin
        issue      = 1'b0;
        last_issue = 1'b0;
      end
    endcase
  end

  // Numeric extraction from the five gathered bytes
  assign rd_byte  = rd_hit ? mem_q : 8'd0;
  assign word     = {rd_byte, acc};
  assign shifted  = 32'(word >> cur.shift);
  assign mask     = 32'hFFFF_FFFF >> (6'd32 - cur.size);
  assign signmask = ~(mask >> 1);

  always_comb begin
    ext = shifted & mask;
    if (cur.sgn && ((ext & signmask) != 32'd0)) begin
      ext = ext | signmask;
    end
    unique case (cur.wclass)
      psx_pkg::WC_8:  ext = ext & 32'h0000_00FF;
      psx_pkg::WC_16: ext = ext & 32'h0000_FFFF;
      default:        ext = ext;
    endcase
  end

  // Result selection
  always_comb begin
    res_push = 1'b0;
    res_in   = '0;
    if (rd_pend) begin
      res_push = !rd_num || rd_last;
      if (rd_num) begin
        res_in.value = ext;
        res_in.last  = 1'b1;
      end else begin
        res_in.value = 32'(rd_byte);
        res_in.last  = rd_last;
      end
      res_in.status = psx_pkg::ST_OK;
    end else if (idle_push) begin
      res_push      = 1'b1;
      res_in.value  = 32'd0;
      res_in.status = idle_status;
      res_in.last   = 1'b1;
    end
  end

  // PDU buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cmd.addr[AW-1:0]] <= cmd.data;
    end
    if (issue) begin
      mem_q <= mem[idx9[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[cmd.addr[AW-1:0]] <= 1'b1;
    end
  end

  // Payload registers of the executor
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_hit <= idx_ok && written[idx9[AW-1:0]];
    end
    if (rd_pend && rd_num) begin
      acc <= {rd_byte, acc[31:8]};
    end
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  // Executor control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      k       <= '0;
      rd_pend <= 1'b0;
      rd_num  <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      rd_pend <= issue;
      rd_num  <= (state == ST_NUM);
      rd_last <= last_issue;
      unique case (state)
        ST_IDLE: begin
          k <= '0;
          if (cmd_pop && cmd.op == psx_pkg::OP_NUM) begin
            state <= ST_NUM;
          end else if (cmd_pop && cmd.op == psx_pkg::OP_COPY) begin
            state <= ST_COPY;
          end
        end
        ST_NUM, ST_COPY: begin
          if (issue) begin
            k <= k + 7'd1;
            if (last_issue) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result queue
  assign rq_pop    = out_valid && !out_stall;
  assign out_valid = (rq_cnt != '0);
  assign value     = rq[rq_rp].value;
  assign status    = rq[rq_rp].status;
  assign last      = rq[rq_rp].last;

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[rq_wp] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wp  <= '0;
      rq_rp  <= '0;
      rq_cnt <= '0;
    end else begin
      if (res_push) begin
        rq_wp <= rq_wp + 1'b1;
      end
      if (rq_pop) begin
        rq_rp <= rq_rp + 1'b1;
      end
      rq_cnt <= rq_cnt + (psx_pkg::RQ_AW+1)'(res_push) - (psx_pkg::RQ_AW+1)'(rq_pop);
    end
  end

endmodule

// ===== hdl/pdu_signal_extractor_core.sv =====
// Top level of the PDU signal extractor.
// Unpacks signals from a PDU byte buffer of PDU_BYTES bytes (zero after reset). A write
// transaction stores one byte. A numeric extract reads five bytes through the single
// buffer read port, one per cycle, then masks and sign-extends. An opaque copy streams
// one byte result per cycle while the result queue has room. The executor waits for its
// last read to drain before it takes the next item. A two-entry command queue sits in
// front of the executor and a four-entry result queue behind it, so input and output
// stall independently.
module pdu_signal_extractor_core #(
  parameter int PDU_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [5:0]  byte_index,
  input  logic [7:0]  byte_value,
  input  logic [8:0]  bit_position,
  input  logic [9:0]  bit_size,
  input  logic [1:0]  endianness,
  input  logic [3:0]  signal_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value,
  output logic [1:0]  status,
  output logic        last
);

  logic          cmd_valid;
  psx_pkg::cmd_t cmd;
  logic          cmd_pop;

  // Classifier and command queue
  psx_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .byte_index   (byte_index),
    .byte_value   (byte_value),
    .bit_position (bit_position),
    .bit_size     (bit_size),
    .endianness   (endianness),
    .signal_type  (signal_type),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Executor with buffer and result queue
  psx_back #(
    .PDU_BYTES (PDU_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status),
    .last      (last)
  );

endmodule

// ===== hdl/psx_checker.sv =====
// Port-level checks for the PDU signal extractor, bound to the top level.
module psx_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] value,
  input logic [1:0]  status,
  input logic        last
);

  // Reset empties both queues
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("queues not empty after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(status) && $stable(last))
    else $error("stalled result changed");

  // Error results are single, final and zero
  a_err_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != psx_pkg::ST_OK |-> last && value == 32'd0)
    else $error("error result not final or not zero");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == psx_pkg::ST_OK || status == psx_pkg::ST_UNSUP ||
                  status == psx_pkg::ST_EMPTY)
    else $error("undefined status code");

  // Input stall only rises after an accepted transaction
  a_in_stall_rise: assert property (@(posedge clk) disable iff (rst)
    !in_valid && !in_stall |=> !in_stall)
    else $error("input stall rose without an accepted transaction");

endmodule

bind pdu_signal_extractor_core psx_checker u_psx_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value     (value),
  .status    (status),
  .last      (last)
);

// ===== test/pdu_signal_extractor_checker.sv =====
// Checker for the PDU signal extractor: watches both channels, predicts results, compares.
module pdu_signal_extractor_checker #(
  parameter int PDU_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        kind,
  input  logic [5:0]  byte_index,
  input  logic [7:0]  byte_value,
  input  logic [8:0]  bit_position,
  input  logic [9:0]  bit_size,
  input  logic [1:0]  endianness,
  input  logic [3:0]  signal_type,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] value,
  input  logic [1:0]  status,
  input  logic        last,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the PDU buffer and the results still owed by the block
  logic [7:0]     pdu_shadow [PDU_BYTES];
  psx_pkg::res_t  expected_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Bytes outside the buffer read as zero, below index 0 as well
  function automatic logic [7:0] pdu_byte(input int idx);
    if (idx < 0 || idx >= PDU_BYTES) return 8'h00;
    return pdu_shadow[idx];
  endfunction

  // Collect 32 bits around the anchor byte plus a fifth byte for shifted signals
  function automatic logic [31:0] gather_bits(input int unsigned pos, input int unsigned nbits,
                                              input logic big);
    int          anchor;
    int unsigned sh;
    logic [31:0] data;
    logic [31:0] extra;
    anchor = pos / 8;
    sh     = pos % 8;
    if (big) begin
      data  = {pdu_byte(anchor - 3), pdu_byte(anchor - 2), pdu_byte(anchor - 1),
               pdu_byte(anchor)};
      extra = {24'd0, pdu_byte(anchor - 4)};
    end else begin
      data  = {pdu_byte(anchor + 3), pdu_byte(anchor + 2), pdu_byte(anchor + 1),
               pdu_byte(anchor)};
      extra = {24'd0, pdu_byte(anchor + 4)};
    end
    data = data >> sh;
    if (sh != 0 && (32 - sh) < nbits) data = data | (extra << (32 - sh));
    return data;
  endfunction

  function automatic void owe_result(input logic [31:0] v, input logic [1:0] st, input logic l);
    psx_pkg::res_t r;
    r.value  = v;
    r.status = st;
    r.last   = l;
    expected_results.push_back(r);
  endfunction

  // Work out every result one extract transaction produces
  function automatic void predict_extract(input logic [8:0] pos, input logic [9:0] size,
                                          input logic [1:0] endian, input logic [3:0] sig_type);
    int unsigned n;
    int unsigned start;
    int unsigned nbits;
    logic [31:0] data;
    logic [31:0] mask;
    logic [31:0] signmask;
    logic        is_signed;
    if (endian == psx_pkg::END_OPAQUE || sig_type == psx_pkg::TY_U8_ARRAY) begin
      // Byte copy, capped at 64 bytes
      n     = size / 8;
      start = pos / 8;
      if (n == 0) begin
        owe_result(32'd0, psx_pkg::ST_EMPTY, 1'b1);
      end else begin
        if (n > psx_pkg::MAX_COPY) n = psx_pkg::MAX_COPY;
        for (int unsigned k = 0; k < n; k++)
          owe_result({24'd0, pdu_byte(int'(start + k))}, psx_pkg::ST_OK, k + 1 == n);
      end
    end else if (endian == psx_pkg::END_RSVD || sig_type == psx_pkg::TY_U64 ||
                 sig_type == psx_pkg::TY_DYN || sig_type >= psx_pkg::TY_S64) begin
      owe_result(32'd0, psx_pkg::ST_UNSUP, 1'b1);
    end else begin
      // Numeric signal: clamp size, mask, sign-extend, truncate to the type
      nbits = (size == 0) ? 1 : (size > 32) ? 32 : size;
      is_signed = (sig_type == psx_pkg::TY_S8 || sig_type == psx_pkg::TY_S16 ||
                   sig_type == psx_pkg::TY_S32);
      data = gather_bits(pos, nbits, endian == psx_pkg::END_BIG);
      mask = 32'hFFFF_FFFF >> (32 - nbits);
      data = data & mask;
      signmask = ~(mask >> 1);
      if (is_signed && (data & signmask) != 0) data = data | signmask;
      if (sig_type == psx_pkg::TY_BOOL || sig_type == psx_pkg::TY_U8 ||
          sig_type == psx_pkg::TY_S8)
        data = data & 32'h0000_00FF;
      else if (sig_type == psx_pkg::TY_U16 || sig_type == psx_pkg::TY_S16)
        data = data & 32'h0000_FFFF;
      owe_result(data, psx_pkg::ST_OK, 1'b1);
    end
  endfunction

  // Compare results first, then take in the new transaction
  always @(posedge clk) begin
    psx_pkg::res_t want;
    if (rst) begin
      for (int i = 0; i < PDU_BYTES; i++) pdu_shadow[i] = 8'h00;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%h status=%0d last=%0d",
                                    value, status, last));
        end else begin
          want = expected_results.pop_front();
          if (value !== want.value)
            report_mismatch($sformatf("value %h, expected %h", value, want.value));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
        end
      end
      if (in_valid && !in_stall) begin
        if (kind == psx_pkg::KIND_WRITE) begin
          if (byte_index < PDU_BYTES) pdu_shadow[byte_index] = byte_value;
        end else begin
          predict_extract(bit_position, bit_size, endianness, signal_type);
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== test/pdu_signal_extractor_core_test.sv =====
// Testbench top for the PDU signal extractor: stimulus, flow control and verdict.
module pdu_signal_extractor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PDU_BYTES      = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int PHASE_ITEMS    = 89;

  logic        clk;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic        kind         = psx_pkg::KIND_WRITE;
  logic [5:0]  byte_index   = '0;
  logic [7:0]  byte_value   = '0;
  logic [8:0]  bit_position = '0;
  logic [9:0]  bit_size     = '0;
  logic [1:0]  endianness   = psx_pkg::END_BIG;
  logic [3:0]  signal_type  = psx_pkg::TY_BOOL;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [31:0] value;
  logic [1:0]  status;
  logic        last;

  int mismatches;
  int outstanding;
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int idle_cycles  = 0;

  pdu_signal_extractor_core #(.PDU_BYTES(PDU_BYTES)) u_dut (
    .clk, .rst, .in_valid, .in_stall, .kind, .byte_index, .byte_value, .bit_position,
    .bit_size, .endianness, .signal_type, .out_valid, .out_stall, .value, .status, .last
  );

  pdu_signal_extractor_checker #(.PDU_BYTES(PDU_BYTES)) u_checker (
    .clk, .rst, .in_valid, .in_stall, .kind, .byte_index, .byte_value, .bit_position,
    .bit_size, .endianness, .signal_type, .out_valid, .out_stall, .value, .status, .last,
    .mismatches, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure
  always @(negedge clk)
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** pdu_signal_extractor_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one transaction from a falling edge and hold it until accepted
  task automatic push_item(input logic k, input logic [5:0] idx, input logic [7:0] val,
                           input logic [8:0] pos, input logic [9:0] size,
                           input logic [1:0] endian, input logic [3:0] sig_type);
    logic taken;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    byte_index   <= idx;
    byte_value   <= val;
    bit_position <= pos;
    bit_size     <= size;
    endianness   <= endian;
    signal_type  <= sig_type;
    do begin
      @(posedge clk);
      taken = !in_stall;
    end while (!taken);
    @(negedge clk);
  endtask

  task automatic write_byte(input logic [5:0] idx, input logic [7:0] val);
    push_item(psx_pkg::KIND_WRITE, idx, val, 9'($urandom), 10'($urandom), 2'($urandom),
              4'($urandom));
  endtask

  task automatic extract(input logic [8:0] pos, input logic [9:0] size,
                         input logic [1:0] endian, input logic [3:0] sig_type);
    push_item(psx_pkg::KIND_EXTRACT, 6'($urandom), 8'($urandom), pos, size, endian, sig_type);
  endtask

  // Byte writes and extracts: mostly well-formed numeric extracts, some copies, some noise
  task automatic random_item();
    logic [3:0] num_types [7] = '{psx_pkg::TY_BOOL, psx_pkg::TY_U8, psx_pkg::TY_U16,
                                  psx_pkg::TY_U32, psx_pkg::TY_S8, psx_pkg::TY_S16,
                                  psx_pkg::TY_S32};
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 38) begin
      write_byte(6'($urandom), 8'($urandom));
    end else if (pick < 80) begin
      extract(9'($urandom), 10'($urandom_range(1, 32)), 2'($urandom_range(0, 1)),
              num_types[$urandom_range(0, 6)]);
    end else if (pick < 92) begin
      extract(9'($urandom),
              ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 80)),
              ($urandom_range(1) == 0) ? psx_pkg::END_OPAQUE : 2'($urandom),
              ($urandom_range(1) == 0) ? psx_pkg::TY_U8_ARRAY : 4'($urandom));
    end else begin
      extract(9'($urandom), 10'($urandom), 2'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: buffer edges, size clamps, sign bits, every type and byte order
    write_byte(6'd0, 8'hFF);
    write_byte(6'd63, 8'h80);
    write_byte(6'd1, 8'h01);
    write_byte(6'd2, 8'hA5);
    extract(9'd0, 10'd0, psx_pkg::END_BIG, psx_pkg::TY_U8);
    extract(9'd511, 10'd1023, psx_pkg::END_LITTLE, psx_pkg::TY_S32);
    extract(9'd5, 10'd32, psx_pkg::END_LITTLE, psx_pkg::TY_U32);
    extract(9'd6, 10'd30, psx_pkg::END_BIG, psx_pkg::TY_S16);
    extract(9'd504, 10'd8, psx_pkg::END_BIG, psx_pkg::TY_S8);
    extract(9'd0, 10'd12, psx_pkg::END_LITTLE, psx_pkg::TY_BOOL);
    extract(9'd0, 10'd7, psx_pkg::END_OPAQUE, psx_pkg::TY_U8);
    extract(9'd496, 10'd1023, psx_pkg::END_OPAQUE, psx_pkg::TY_U32);
    extract(9'd8, 10'd24, psx_pkg::END_BIG, psx_pkg::TY_U8_ARRAY);
    extract(9'd0, 10'd8, psx_pkg::END_RSVD, psx_pkg::TY_U8);
    extract(9'd0, 10'd8, psx_pkg::END_RSVD, psx_pkg::TY_U8_ARRAY);
    extract(9'd0, 10'd64, psx_pkg::END_LITTLE, psx_pkg::TY_U64);
    extract(9'd0, 10'd8, psx_pkg::END_BIG, psx_pkg::TY_DYN);
    extract(9'd0, 10'd64, psx_pkg::END_LITTLE, psx_pkg::TY_S64);
    extract(9'd0, 10'd8, psx_pkg::END_BIG, 4'hF);
    extract(9'd3, 10'd8, psx_pkg::END_LITTLE, psx_pkg::TY_S8);
    extract(9'd0, 10'd16, psx_pkg::END_LITTLE, psx_pkg::TY_U16);
    extract(9'd7, 10'd16, psx_pkg::END_LITTLE, psx_pkg::TY_S16);
    extract(9'd31, 10'd32, psx_pkg::END_BIG, psx_pkg::TY_S32);

    // Random phases with different flow-control pressure
    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 62; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 62; end
        default: begin send_gap_pct = 29; stall_pct = 29; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("** pdu_signal_extractor_core: PASSED **");
    else
      $display("** pdu_signal_extractor_core: FAILED **");
    $finish;
  end

endmodule
